>>> sv/lrupr_pkg.sv
// Package: shared constants and controller/datapath command type for the LRU unit.
`default_nettype none

package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int SLOT_W     = 3;
    localparam int AGE_W      = 3;
    localparam int CNT_W      = 4;
    localparam int FAULT_W    = 32;
    localparam int TDATA_W    = 56;
    localparam int TUSER_W    = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_FRAMES - 1);

    typedef struct packed {
        logic capture;   // latch the incoming page
        logic commit;    // look up, update frames, load result
    } lrupr_cmd_t;

endpackage

`default_nettype wire

>>> sv/lrupr_ctrl.sv
// Controller: handshake state machine issuing capture and commit commands.
`default_nettype none

module lrupr_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output lrupr_pkg::lrupr_cmd_t cmd
);
    import lrupr_pkg::*;

    typedef enum logic {ST_IDLE, ST_WORK} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = out_valid_reg;
    assign cmd.capture = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.commit  = (state_reg == ST_WORK) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                if (cmd.commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    // never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while stalled");
    // a commit always produces a pending result
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("commit did not raise m_tvalid");
`endif

endmodule

`default_nettype wire

>>> sv/lrupr_datapath.sv
// Datapath: frame table, parallel lookup, recency update and result registers.
`default_nettype none

module lrupr_datapath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_wr_en,
    input  wire  [lrupr_pkg::CNT_W-1:0]       cfg_wr_data,
    input  wire  [lrupr_pkg::PAGE_BITS-1:0]   page_in,
    input  wire  lrupr_pkg::lrupr_cmd_t       cmd,
    output logic [lrupr_pkg::TDATA_W-1:0]     res_data,
    output logic [lrupr_pkg::TUSER_W-1:0]     res_user
);
    import lrupr_pkg::*;

    logic [CNT_W-1:0]     fiu_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [PAGE_BITS-1:0] frame_page_reg [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] frame_valid_reg, frame_valid_next;
    logic [AGE_W-1:0]     frame_age_reg  [MAX_FRAMES];
    logic [AGE_W-1:0]     frame_age_next [MAX_FRAMES];
    logic [FAULT_W-1:0]   fault_reg, fault_next;

    logic                 res_hit_reg, res_ev_valid_reg;
    logic [SLOT_W-1:0]    res_slot_reg;
    logic [PAGE_BITS-1:0] res_ev_page_reg;

    logic [CNT_W-1:0]     n_act;
    logic [MAX_FRAMES-1:0] active;
    logic                 hit_c, empty_c;
    logic [SLOT_W-1:0]    hit_slot, empty_slot, lru_slot, slot_c;
    logic [AGE_W-1:0]     oldest;
    logic [AGE_W:0]       old_age;
    logic                 ev_valid_c;
    logic [PAGE_BITS-1:0] ev_page_c;

    // clamp frames_in_use to 1..MAX_FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (fiu_reg > CNT_W'(MAX_FRAMES))
        begin
            n_act = CNT_W'(MAX_FRAMES);
        end
        else
        begin
            n_act = fiu_reg;
        end
    end

    // lookup: first hit, first empty, first oldest among active frames
    always_comb
    begin
        hit_c      = 1'b0;
        empty_c    = 1'b0;
        hit_slot   = '0;
        empty_slot = '0;
        lru_slot   = '0;
        oldest     = frame_age_reg[0];
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            active[i] = (CNT_W'(i) < n_act);
            if (active[i] && frame_valid_reg[i] && (frame_page_reg[i] == page_reg) && !hit_c)
            begin
                hit_c    = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (active[i] && !frame_valid_reg[i] && !empty_c)
            begin
                empty_c    = 1'b1;
                empty_slot = SLOT_W'(i);
            end
            if (active[i] && (frame_age_reg[i] > oldest))
            begin
                oldest   = frame_age_reg[i];
                lru_slot = SLOT_W'(i);
            end
        end
    end

    // slot choice and recency update
    always_comb
    begin
        priority if (hit_c)
        begin
            slot_c = hit_slot;
        end
        else if (empty_c)
        begin
            slot_c = empty_slot;
        end
        else
        begin
            slot_c = lru_slot;
        end
        ev_valid_c = !hit_c && !empty_c;
        ev_page_c  = ev_valid_c ? frame_page_reg[slot_c] : '0;
        old_age    = hit_c ? {1'b0, frame_age_reg[slot_c]} : (AGE_W+1)'(MAX_FRAMES);

        frame_valid_next = frame_valid_reg;
        if (!hit_c)
        begin
            frame_valid_next[slot_c] = 1'b1;
        end
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_age_next[i] = frame_age_reg[i];
            if (SLOT_W'(i) == slot_c)
            begin
                frame_age_next[i] = '0;
            end
            else if (active[i] && frame_valid_reg[i]
                     && ({1'b0, frame_age_reg[i]} < old_age)
                     && (frame_age_reg[i] < AGE_MAX))
            begin
                frame_age_next[i] = frame_age_reg[i] + AGE_W'(1);
            end
        end

        fault_next = fault_reg;
        if (!hit_c && (fault_reg != '1))
        begin
            fault_next = fault_reg + FAULT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg         <= CNT_W'(MAX_FRAMES);
            frame_valid_reg <= '0;
            fault_reg       <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                frame_age_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                fiu_reg <= cfg_wr_data;
            end
            if (cmd.commit)
            begin
                frame_valid_reg <= frame_valid_next;
                fault_reg       <= fault_next;
                for (int i = 0; i < MAX_FRAMES; i++)
                begin
                    frame_age_reg[i] <= frame_age_next[i];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg <= page_in;
        end
        if (cmd.commit)
        begin
            if (!hit_c)
            begin
                frame_page_reg[slot_c] <= page_reg;
            end
            res_hit_reg      <= hit_c;
            res_slot_reg     <= slot_c;
            res_ev_valid_reg <= ev_valid_c;
            res_ev_page_reg  <= ev_page_c;
        end
    end

    // tdata: frame_slot, evicted_page, fault_count, zero pad
    assign res_data = {{(TDATA_W - SLOT_W - PAGE_BITS - FAULT_W){1'b0}},
                       fault_reg, res_ev_page_reg, res_slot_reg};
    assign res_user = {res_ev_valid_reg, res_hit_reg};

`ifndef SYNTH
    // the frame just used is resident and most recent
    a_slot_mru: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (frame_valid_reg[res_slot_reg] && (frame_age_reg[res_slot_reg] == '0)))
        else $error("used frame not most recent");
    // every miss bumps the fault counter unless saturated
    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !hit_c) |=>
            ((fault_reg == $past(fault_reg) + FAULT_W'(1)) || ($past(fault_reg) == '1)))
        else $error("fault counter not advanced on miss");
    // a hit leaves the fault counter alone
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit_c) |=> $stable(fault_reg))
        else $error("fault counter changed on hit");
`endif

endmodule

`default_nettype wire

>>> sv/lru_page_replacement.sv
// Top level: LRU page replacement unit, stream in, stream out, one config register.
`default_nettype none

// Takes one page reference per transaction on the s_ side and returns one result
// transaction on the m_ side: hit or fault, the frame holding the page, the evicted
// page if one was replaced, and the saturating fault count. Up to eight frames take
// part, set by cfg_wr_data (frames_in_use, 0 acts as 1, above 8 acts as 8; reset 8).
// Frames outside the active range keep their contents and are left alone. A miss
// fills the lowest empty active frame, else replaces the oldest active frame (lowest
// index on ties). Each reference is handled in order: the page is captured, then the
// eight-way compare and recency update run in the datapath. The result register lets
// the next page be captured while the previous result waits; a stall that lasts past
// that capture delays the next commit, and so the next capture. No clearing pass
// after reset. Write the config only while no transaction is in flight.
module lru_page_replacement (
    input  wire                              clk,
    input  wire                              rst_n,
    // config
    input  wire                              cfg_wr_en,
    input  wire  [lrupr_pkg::CNT_W-1:0]      cfg_wr_data,  // frames_in_use
    // page references
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [lrupr_pkg::PAGE_BITS-1:0]  s_tdata,      // [15:0] page
    // results
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // [2:0] frame_slot, [18:3] evicted_page, [50:19] fault_count, [55:51] zero
    output logic [lrupr_pkg::TDATA_W-1:0]    m_tdata,
    // [0] hit, [1] evicted_valid
    output logic [lrupr_pkg::TUSER_W-1:0]    m_tuser
);
    import lrupr_pkg::*;

    lrupr_cmd_t cmd;

    lrupr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lrupr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .page_in     (s_tdata),
        .cmd         (cmd),
        .res_data    (m_tdata),
        .res_user    (m_tuser)
    );

`ifndef SYNTH
    // an eviction only happens on a fault
    a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("eviction reported on a hit");
`endif

endmodule

`default_nettype wire
